@@ hw/rtl/fw2d_pkg.sv @@
`default_nettype none

package fw2d_pkg;

  // grid bounds of the tree (power of two, so an address is {row, col})
  localparam int unsigned MaxRows = 64;
  localparam int unsigned MaxCols = 64;

  localparam int unsigned RowW   = $clog2(MaxRows);
  localparam int unsigned ColW   = $clog2(MaxCols);
  localparam int unsigned AddrW  = RowW + ColW;
  localparam int unsigned Depth  = MaxRows * MaxCols;

  // one-based chain indices, wide enough for index plus lowbit
  localparam int unsigned RIdxW  = RowW + 2;
  localparam int unsigned CIdxW  = ColW + 2;

  localparam int unsigned ShapeW = 7;
  localparam int unsigned DataW  = 32;

  // configuration register indexes
  localparam logic RegRows = 1'b0;
  localparam logic RegCols = 1'b1;

  // command codes
  localparam logic CmdSet   = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // status codes
  localparam logic StatOk  = 1'b0;
  localparam logic StatErr = 1'b1;

  // memory requests from the sequencer to the store
  typedef struct packed {
    logic             tree_re;
    logic             tree_we;
    logic [AddrW-1:0] tree_addr;
    logic [DataW-1:0] tree_wdata;
    logic             raw_re;
    logic             raw_we;
    logic [AddrW-1:0] raw_addr;
    logic [DataW-1:0] raw_wdata;
  } mem_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/fw2d_store.sv @@
`default_nettype none

module fw2d_store import fw2d_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mem_req_t         req_i,
  output logic [DataW-1:0]      tree_rdata_o,
  output logic [DataW-1:0]      raw_rdata_o,
  output logic                  busy_o
);

  logic [DataW-1:0] tree_mem [Depth];
  logic [DataW-1:0] raw_mem  [Depth];

  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic             clr_busy_q, clr_busy_d;

  logic             tree_we, raw_we;
  logic [AddrW-1:0] tree_addr, raw_addr;
  logic [DataW-1:0] tree_wdata, raw_wdata;
  logic [DataW-1:0] tree_rdata_q, raw_rdata_q;

  // clearing pass after reset, one entry of each store per cycle
  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == AddrW'(Depth - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // port muxing between clear pass and sequencer
  always_comb begin
    tree_we    = clr_busy_q | req_i.tree_we;
    raw_we     = clr_busy_q | req_i.raw_we;
    tree_addr  = clr_busy_q ? clr_cnt_q : req_i.tree_addr;
    raw_addr   = clr_busy_q ? clr_cnt_q : req_i.raw_addr;
    tree_wdata = clr_busy_q ? '0 : req_i.tree_wdata;
    raw_wdata  = clr_busy_q ? '0 : req_i.raw_wdata;
  end

  // tree memory, registered read
  always_ff @(posedge clk_i) begin
    if (tree_we) begin
      tree_mem[tree_addr] <= tree_wdata;
    end
    if (req_i.tree_re) begin
      tree_rdata_q <= tree_mem[tree_addr];
    end
  end

  // raw cell memory, registered read
  always_ff @(posedge clk_i) begin
    if (raw_we) begin
      raw_mem[raw_addr] <= raw_wdata;
    end
    if (req_i.raw_re) begin
      raw_rdata_q <= raw_mem[raw_addr];
    end
  end

  assign tree_rdata_o = tree_rdata_q;
  assign raw_rdata_o  = raw_rdata_q;
  assign busy_o       = clr_busy_q;

endmodule

`default_nettype wire

@@ hw/rtl/fenwick_2d_range_sum.sv @@
`default_nettype none
// set: raw cell read, raw write with delta, then a tree read and write per node of row chain x col chain
// query: 4 prefix walks at one tree read per cycle, each after a setup step
// an out-of-shape item goes straight to an error result; one item at a time
// reset clears control state, then a clearing pass zeroes both stores before any word
// is taken (configuration writes are taken throughout)
module fenwick_2d_range_sum import fw2d_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration write channel
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_index_i,
  input  wire logic [ShapeW-1:0] cfg_data_i,
  // input stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // row_a[5:0], col_a[11:6], row_b[17:12], col_b[23:18], new_value[55:24]
  input  wire logic [55:0]       s_axis_tdata,
  // cmd[0]
  input  wire logic [0:0]        s_axis_tuser,
  // result stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // region_sum[31:0]
  output logic [31:0]            m_axis_tdata,
  // status[0]
  output logic [0:0]             m_axis_tuser
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StURaw = 4'd1;
  localparam logic [3:0] StUDlt = 4'd2;
  localparam logic [3:0] StUTrd = 4'd3;
  localparam logic [3:0] StUTwr = 4'd4;
  localparam logic [3:0] StQIni = 4'd5;
  localparam logic [3:0] StQRun = 4'd6;
  localparam logic [3:0] StQDrn = 4'd7;
  localparam logic [3:0] StDone = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [ShapeW-1:0] rows_q, rows_d, cols_q, cols_d;
  logic              cmd_q, cmd_d, err_q, err_d;
  logic [RowW-1:0]   ra_q, ra_d, rb_q, rb_d;
  logic [ColW-1:0]   ca_q, ca_d, cb_q, cb_d;
  logic [DataW-1:0]  val_q, val_d, delta_q, delta_d, acc_q, acc_d;
  logic [RIdxW-1:0]  i_q, i_d;
  logic [CIdxW-1:0]  j_q, j_d;
  logic [1:0]        corner_q, corner_d;
  logic              pend_q, pend_d, pend_neg_q, pend_neg_d;
  logic              m_valid_q, m_valid_d;
  logic [DataW-1:0]  m_data_q, m_data_d;
  logic              m_user_q, m_user_d;

  mem_req_t          req;
  logic [DataW-1:0]  tree_rdata, raw_rdata;
  logic              busy;

  logic [ShapeW-1:0] rows_eff, cols_eff;
  logic [RowW-1:0]   in_ra, in_rb;
  logic [ColW-1:0]   in_ca, in_cb;
  logic              in_err, s_acc;
  logic [RIdxW-1:0]  r_sel, i_up, i_dn;
  logic [CIdxW-1:0]  c_sel, j_up, j_dn;
  logic [AddrW-1:0]  tree_addr;
  logic [RowW-1:0]   i_m1;
  logic [ColW-1:0]   j_m1;

  fw2d_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .tree_rdata_o (tree_rdata),
    .raw_rdata_o  (raw_rdata),
    .busy_o       (busy)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle) && !busy;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // input unpacking and shape check
  always_comb begin
    in_ra    = s_axis_tdata[5:0];
    in_ca    = s_axis_tdata[11:6];
    in_rb    = s_axis_tdata[17:12];
    in_cb    = s_axis_tdata[23:18];
    rows_eff = (rows_q > ShapeW'(MaxRows)) ? ShapeW'(MaxRows) : rows_q;
    cols_eff = (cols_q > ShapeW'(MaxCols)) ? ShapeW'(MaxCols) : cols_q;
    in_err   = (ShapeW'(in_ra) >= rows_eff) || (ShapeW'(in_ca) >= cols_eff);
    if (s_axis_tuser[0] == CmdQuery) begin
      in_err = in_err || (ShapeW'(in_rb) >= rows_eff) || (ShapeW'(in_cb) >= cols_eff);
    end
  end

  // index chain steps and corner selection
  always_comb begin
    i_up  = i_q + (i_q & (~i_q + RIdxW'(1)));
    j_up  = j_q + (j_q & (~j_q + CIdxW'(1)));
    i_dn  = i_q & (i_q - RIdxW'(1));
    j_dn  = j_q & (j_q - CIdxW'(1));
    r_sel = corner_q[0] ? RIdxW'(ra_q) : RIdxW'(rb_q) + RIdxW'(1);
    c_sel = corner_q[1] ? CIdxW'(ca_q) : CIdxW'(cb_q) + CIdxW'(1);
    i_m1  = RowW'(i_q - RIdxW'(1));
    j_m1  = ColW'(j_q - CIdxW'(1));
    tree_addr = {i_m1, j_m1};
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    rows_d     = rows_q;
    cols_d     = cols_q;
    cmd_d      = cmd_q;
    err_d      = err_q;
    ra_d       = ra_q;
    ca_d       = ca_q;
    rb_d       = rb_q;
    cb_d       = cb_q;
    val_d      = val_q;
    delta_d    = delta_q;
    acc_d      = acc_q;
    i_d        = i_q;
    j_d        = j_q;
    corner_d   = corner_q;
    pend_d     = 1'b0;
    pend_neg_d = pend_neg_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;

    req            = '0;
    req.tree_addr  = tree_addr;
    req.tree_wdata = tree_rdata + delta_q;
    req.raw_addr   = {ra_q, ca_q};
    req.raw_wdata  = val_q;

    // config register writes
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRows: rows_d = cfg_data_i;
        RegCols: cols_d = cfg_data_i;
        default: ;
      endcase
    end

    // result word leaves
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    // accumulate the tree word read in the previous cycle
    if (pend_q) begin
      acc_d = pend_neg_q ? acc_q - tree_rdata : acc_q + tree_rdata;
    end

    case (state_q)
      StIdle: begin
        if (s_acc) begin
          cmd_d    = s_axis_tuser[0];
          ra_d     = in_ra;
          ca_d     = in_ca;
          rb_d     = in_rb;
          cb_d     = in_cb;
          val_d    = s_axis_tdata[55:24];
          err_d    = in_err;
          acc_d    = '0;
          corner_d = '0;
          if (in_err) begin
            state_d = StDone;
          end else if (s_axis_tuser[0] == CmdQuery) begin
            state_d = StQIni;
          end else begin
            state_d = StURaw;
          end
        end
      end
      StURaw: begin
        req.raw_re = 1'b1;
        state_d    = StUDlt;
      end
      StUDlt: begin
        delta_d    = val_q - raw_rdata;
        req.raw_we = 1'b1;
        i_d        = RIdxW'(ra_q) + RIdxW'(1);
        j_d        = CIdxW'(ca_q) + CIdxW'(1);
        state_d    = StUTrd;
      end
      StUTrd: begin
        req.tree_re = 1'b1;
        state_d     = StUTwr;
      end
      StUTwr: begin
        req.tree_we = 1'b1;
        state_d     = StUTrd;
        if (j_up > CIdxW'(MaxCols)) begin
          if (i_up > RIdxW'(MaxRows)) begin
            state_d = StDone;
          end else begin
            i_d = i_up;
            j_d = CIdxW'(ca_q) + CIdxW'(1);
          end
        end else begin
          j_d = j_up;
        end
      end
      StQIni: begin
        if (r_sel == '0 || c_sel == '0) begin
          corner_d = corner_q + 2'd1;
          if (corner_q == 2'd3) begin
            state_d = StQDrn;
          end
        end else begin
          i_d     = r_sel;
          j_d     = c_sel;
          state_d = StQRun;
        end
      end
      StQRun: begin
        req.tree_re = 1'b1;
        pend_d      = 1'b1;
        pend_neg_d  = corner_q[0] ^ corner_q[1];
        if (j_dn == '0) begin
          if (i_dn == '0) begin
            corner_d = corner_q + 2'd1;
            state_d  = (corner_q == 2'd3) ? StQDrn : StQIni;
          end else begin
            i_d = i_dn;
            j_d = c_sel;
          end
        end else begin
          j_d = j_dn;
        end
      end
      StQDrn: begin
        state_d = StDone;
      end
      StDone: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = (cmd_q == CmdQuery && !err_q) ? acc_q : '0;
          m_user_d  = err_q ? StatErr : StatOk;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      rows_q    <= ShapeW'(MaxRows);
      cols_q    <= ShapeW'(MaxCols);
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rows_q    <= rows_d;
      cols_q    <= cols_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    err_q      <= err_d;
    ra_q       <= ra_d;
    ca_q       <= ca_d;
    rb_q       <= rb_d;
    cb_q       <= cb_d;
    val_q      <= val_d;
    delta_q    <= delta_d;
    acc_q      <= acc_d;
    i_q        <= i_d;
    j_q        <= j_d;
    corner_q   <= corner_d;
    pend_neg_q <= pend_neg_d;
    m_data_q   <= m_data_d;
    m_user_q   <= m_user_d;
  end

endmodule

`default_nettype wire
